[rtl/core/fat_cluster_chain_lookup_defines.svh]
// Assertion macros used by the checker file of the cluster chain lookup.
`ifndef FAT_CLUSTER_CHAIN_LOOKUP_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define FCCL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fccl assertion failed");

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define FCCL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fccl assertion failed");

`endif

[rtl/core/fccl_pkg.sv]
// Types and constants shared by the cluster chain lookup modules.
package fccl_pkg;

   // FAT copy held in the byte memory.
   localparam int FAT_TABLE_BYTES = 65536;
   localparam int FAT_AW          = $clog2(FAT_TABLE_BYTES);

   // Serial divider sizes.
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 13;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   // Configuration port.
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_IW-1:0] CSR_BPS      = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SPC      = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_RESERVED = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_COPIES   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ROOT     = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_FSHORT   = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_FLONG    = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_VOLUME   = 3'd7;

   // Cluster count limits of the FAT types.
   localparam logic [31:0] LIMIT_FAT12 = 32'd4085;
   localparam logic [31:0] LIMIT_FAT16 = 32'd65525;
   localparam logic [31:0] LIMIT_FAT32 = 32'd268435445;

   // End-of-chain markers.
   localparam logic [27:0] EOC_FAT12 = 28'h0000fff;
   localparam logic [27:0] EOC_FAT16 = 28'h000ffff;
   localparam logic [27:0] EOC_FAT32 = 28'hfffffff;
   localparam logic [7:0]  TOP_MASK  = 8'h0f;

   // FAT kinds.
   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_CONTINUE = 2'd0;
   localparam logic [1:0] ST_END      = 2'd1;
   localparam logic [1:0] ST_UNSUPP   = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   // Input mode codes.
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] byte_address;
      logic [7:0]  byte_value;
      logic [27:0] cluster;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] first_sector;
      logic [27:0] next_cluster;
      logic [1:0]  fat_kind;
   } rsp_type;

   // Derived volume geometry handed to the lookup engine.
   typedef struct packed {
      logic        ready;
      logic        unsupported;
      logic [1:0]  kind;
      logic [31:0] first_data;
      logic [7:0]  spc;
   } geo_type;

endpackage

[rtl/core/fccl_ram.sv]
// Generic single-write, single-read RAM with a registered read.
module fccl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/fccl_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module fccl_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fccl_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [fccl_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              done,
   output logic [fccl_pkg::DIVIDEND_W-1:0]   quotient
);
   import fccl_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Operand load on start, otherwise one shift-and-subtract step while busy.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/fccl_geom.sv]
// Geometry registers and the sequencer that derives the volume layout from them.
module fccl_geom (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [fccl_pkg::CSR_IW-1:0]   csr_index,
   input  logic [fccl_pkg::CSR_DW-1:0]   csr_wdata,
   output fccl_pkg::geo_type             geo
);
   import fccl_pkg::*;

   typedef enum logic [7:0] {
      G_START  = 8'b00000001,
      G_RDIV   = 8'b00000010,
      G_MUL    = 8'b00000100,
      G_OVER   = 8'b00001000,
      G_CSTART = 8'b00010000,
      G_CDIV   = 8'b00100000,
      G_KIND   = 8'b01000000,
      G_DONE   = 8'b10000000
   } gstate_type;

   gstate_type state_ff, state_in;

   logic [12:0] bps_ff;
   logic [7:0]  spc_ff;
   logic [15:0] reserved_ff;
   logic [7:0]  copies_ff;
   logic [15:0] root_ent_ff;
   logic [15:0] fshort_ff;
   logic [31:0] flong_ff;
   logic [31:0] volume_ff;

   logic [21:0] root_ff, root_in;
   logic [39:0] prod_ff, prod_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] data_ff, data_in;
   logic [31:0] clus_ff, clus_in;
   logic        unsup_ff, unsup_in;
   logic [1:0]  kind_ff, kind_in;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quo;
   logic [31:0]           fat_secs;
   logic [40:0]           overhead;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff      <= 13'd512;
         spc_ff      <= 8'd1;
         reserved_ff <= 16'd1;
         copies_ff   <= 8'd2;
         root_ent_ff <= 16'd512;
         fshort_ff   <= '0;
         flong_ff    <= '0;
         volume_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BPS:      bps_ff      <= csr_wdata[12:0];
            CSR_SPC:      spc_ff      <= csr_wdata[7:0];
            CSR_RESERVED: reserved_ff <= csr_wdata[15:0];
            CSR_COPIES:   copies_ff   <= csr_wdata[7:0];
            CSR_ROOT:     root_ent_ff <= csr_wdata[15:0];
            CSR_FSHORT:   fshort_ff   <= csr_wdata[15:0];
            CSR_FLONG:    flong_ff    <= csr_wdata;
            CSR_VOLUME:   volume_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   fccl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Layout sequencer: root sectors, FAT area, data area, cluster count, kind.
   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      first_in     = first_ff;
      data_in      = data_ff;
      clus_in      = clus_ff;
      unsup_in     = unsup_ff;
      kind_in      = kind_ff;
      div_start    = 1'b0;
      div_dividend = DIVIDEND_W'({1'b0, root_ent_ff, 5'b0} + 22'(bps_ff) - 22'd1);
      div_divisor  = bps_ff;
      fat_secs     = (fshort_ff == '0) ? flong_ff : {16'b0, fshort_ff};
      overhead     = 41'(reserved_ff) + 41'(prod_ff) + 41'(root_ff);
      case (state_ff)
         G_START: begin
            unsup_in = 1'b0;
            if (bps_ff == '0) begin
               root_in  = '0;
               state_in = G_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = G_RDIV;
            end
         end
         G_RDIV: begin
            if (div_done) begin
               root_in  = div_quo[21:0];
               state_in = G_MUL;
            end
         end
         G_MUL: begin
            prod_in  = 40'(copies_ff) * 40'(fat_secs);
            state_in = G_OVER;
         end
         G_OVER: begin
            first_in = overhead[31:0];
            data_in  = (overhead > 41'(volume_ff)) ? 32'd0 : volume_ff - overhead[31:0];
            if (spc_ff == '0) begin
               unsup_in = 1'b1;
               state_in = G_DONE;
            end else begin
               state_in = G_CSTART;
            end
         end
         G_CSTART: begin
            div_start    = 1'b1;
            div_dividend = data_ff;
            div_divisor  = DIVISOR_W'(spc_ff);
            state_in     = G_CDIV;
         end
         G_CDIV: begin
            if (div_done) begin
               clus_in  = div_quo;
               state_in = G_KIND;
            end
         end
         G_KIND: begin
            if (clus_ff < LIMIT_FAT12 && fshort_ff != '0) begin
               kind_in = KIND_FAT12;
            end else if (clus_ff < LIMIT_FAT16 && fshort_ff != '0) begin
               kind_in = KIND_FAT16;
            end else if (clus_ff < LIMIT_FAT32) begin
               kind_in = KIND_FAT32;
            end else begin
               kind_in  = KIND_FAT12;
               unsup_in = 1'b1;
            end
            state_in = G_DONE;
         end
         G_DONE: ;
         default: state_in = G_START;
      endcase
      if (csr_we) begin
         state_in = G_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_START;
         unsup_ff <= 1'b0;
         kind_ff  <= KIND_FAT12;
      end else begin
         state_ff <= state_in;
         unsup_ff <= unsup_in;
         kind_ff  <= kind_in;
      end
      root_ff  <= root_in;
      prod_ff  <= prod_in;
      first_ff <= first_in;
      data_ff  <= data_in;
      clus_ff  <= clus_in;
   end

   assign geo.ready       = (state_ff == G_DONE) && !csr_we;
   assign geo.unsupported = unsup_ff;
   assign geo.kind        = unsup_ff ? KIND_FAT12 : kind_ff;
   assign geo.first_data  = first_ff;
   assign geo.spc         = spc_ff;
endmodule

[rtl/core/fat_cluster_chain_lookup.sv]
// Top level of the FAT cluster chain lookup: byte FAT store and lookup engine.
//
//  channel  direction  handshake             carries
//  req      in         req_valid/req_ready   FAT byte write or cluster lookup word
//  rsp      out        rsp_valid/rsp_ready   status, first sector, next cluster, kind
//  csr      in         csr_we                geometry register write
//
// A lookup result is offered after the entry is read one byte per cycle from
// the single read port of the FAT memory, two bytes for FAT12/FAT16 and four
// for FAT32; range and unsupported results skip the reads. The next word can
// be taken in the same cycle as the result is first offered. After reset and
// after every register write the geometry is rederived by up to two 32-step
// serial divisions; req_ready stays low meanwhile. A result still waiting on
// rsp_ready holds the next lookup in its final state.
module fat_cluster_chain_lookup (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  fccl_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output fccl_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [fccl_pkg::CSR_IW-1:0] csr_index,
   input  logic [fccl_pkg::CSR_DW-1:0] csr_wdata
);
   import fccl_pkg::*;

   typedef enum logic [4:0] {
      L_IDLE = 5'b00001,
      L_CALC = 5'b00010,
      L_READ = 5'b00100,
      L_WAIT = 5'b01000,
      L_FIN  = 5'b10000
   } lstate_type;

   lstate_type state_ff, state_in;
   geo_type    geo;

   logic [27:0] clus_ff, clus_in;
   logic [29:0] off_ff, off_in;
   logic        bad_ff, bad_in;
   logic [31:0] mul_ff, mul_in;
   logic [1:0]  nlast_ff, nlast_in;
   logic [1:0]  iss_ff, iss_in;
   logic        rd_vld_ff;
   logic [1:0]  rd_idx_ff;
   logic [7:0]  byte_ff [4];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic              accept;
   logic              mem_we;
   logic [FAT_AW-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;
   logic [29:0]       off_calc;
   logic [29:0]       last_calc;
   logic [15:0]       pair;
   logic [15:0]       pair_sh;
   logic [27:0]       entry;
   logic [27:0]       eoc;

   fccl_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geo       (geo)
   );

   // Byte writes go straight into the store; lookups start only afterwards.
   assign req_ready = (state_ff == L_IDLE) && geo.ready;
   assign accept    = req_valid && req_ready;
   assign mem_we    = accept && (req_data.mode == MODE_WRITE) &&
                      (32'(req_data.byte_address) < 32'(FAT_TABLE_BYTES));
   assign mem_rd_addr = FAT_AW'(off_ff + 30'(iss_ff));

   fccl_ram #(
      .WIDTH (8),
      .DEPTH (FAT_TABLE_BYTES)
   ) u_fat (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (FAT_AW'(req_data.byte_address)),
      .wr_data (req_data.byte_value),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Entry assembly from the gathered bytes.
   always_comb begin
      pair    = {byte_ff[1], byte_ff[0]};
      pair_sh = clus_ff[0] ? (pair >> 4) : pair;
      case (geo.kind)
         KIND_FAT12: begin
            entry = {16'b0, pair_sh[11:0]};
            eoc   = EOC_FAT12;
         end
         KIND_FAT16: begin
            entry = {12'b0, pair};
            eoc   = EOC_FAT16;
         end
         default: begin
            entry = {byte_ff[3][3:0] & TOP_MASK[3:0], byte_ff[2], pair};
            eoc   = EOC_FAT32;
         end
      endcase
   end

   // Lookup sequencer.
   always_comb begin
      state_in     = state_ff;
      clus_in      = clus_ff;
      off_in       = off_ff;
      bad_in       = bad_ff;
      mul_in       = mul_ff;
      nlast_in     = nlast_ff;
      iss_in       = iss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (geo.kind)
         KIND_FAT12: off_calc = 30'(clus_ff) + 30'(clus_ff >> 1);
         KIND_FAT16: off_calc = {1'b0, clus_ff, 1'b0};
         default:    off_calc = {clus_ff, 2'b0};
      endcase
      last_calc = off_calc + ((geo.kind == KIND_FAT32) ? 30'd3 : 30'd1);
      case (state_ff)
         L_IDLE: begin
            if (accept && req_data.mode == MODE_LOOKUP) begin
               clus_in  = req_data.cluster;
               state_in = L_CALC;
            end
         end
         L_CALC: begin
            off_in   = off_calc;
            bad_in   = (clus_ff < 28'd2) || (32'(last_calc) >= 32'(FAT_TABLE_BYTES));
            mul_in   = 32'(32'(clus_ff - 28'd2) * 32'(geo.spc));
            nlast_in = (geo.kind == KIND_FAT32) ? 2'd3 : 2'd1;
            iss_in   = '0;
            if (geo.unsupported || (clus_ff < 28'd2) ||
                (32'(last_calc) >= 32'(FAT_TABLE_BYTES))) begin
               state_in = L_FIN;
            end else begin
               state_in = L_READ;
            end
         end
         L_READ: begin
            iss_in = iss_ff + 2'd1;
            if (iss_ff == nlast_ff) begin
               state_in = L_WAIT;
            end
         end
         L_WAIT: state_in = L_FIN;
         L_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (geo.unsupported) begin
                  rsp_in = '{status: ST_UNSUPP, first_sector: '0, next_cluster: '0,
                             fat_kind: KIND_FAT12};
               end else if (bad_ff) begin
                  rsp_in = '{status: ST_RANGE, first_sector: '0, next_cluster: '0,
                             fat_kind: geo.kind};
               end else begin
                  rsp_in.status       = (entry == eoc) ? ST_END : ST_CONTINUE;
                  rsp_in.first_sector = mul_ff + geo.first_data;
                  rsp_in.next_cluster = entry;
                  rsp_in.fat_kind     = geo.kind;
               end
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= L_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == L_READ);
      end
      clus_ff   <= clus_in;
      off_ff    <= off_in;
      bad_ff    <= bad_in;
      mul_ff    <= mul_in;
      nlast_ff  <= nlast_in;
      iss_ff    <= iss_in;
      rd_idx_ff <= iss_ff;
      rsp_ff    <= rsp_in;
      // Each registered read byte lands in the slot its address was issued for.
      if (rd_vld_ff) begin
         byte_ff[rd_idx_ff] <= mem_rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[rtl/core/fccl_checker.sv]
// Port-level checker for the cluster chain lookup and its bind.
`include "fat_cluster_chain_lookup_defines.svh"

module fccl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input fccl_pkg::req_type           req_data,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input fccl_pkg::rsp_type           rsp_data,
   input logic                        csr_we,
   input logic [fccl_pkg::CSR_IW-1:0] csr_index,
   input logic [fccl_pkg::CSR_DW-1:0] csr_wdata
);
   import fccl_pkg::*;

   // A stalled result stays offered.
   `FCCL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // A byte write never produces a result word.
   `FCCL_ASSERT_NXT(a_write_silent, req_valid && req_ready && req_data.mode == MODE_WRITE && !rsp_valid, !rsp_valid)

   // An unsupported volume reports all other fields as zero.
   `FCCL_ASSERT_IMP(a_unsupp_zero, rsp_valid && rsp_data.status == ST_UNSUPP, rsp_data.first_sector == '0 && rsp_data.next_cluster == '0 && rsp_data.fat_kind == KIND_FAT12)

   // A range error carries no sector and no next cluster.
   `FCCL_ASSERT_IMP(a_range_zero, rsp_valid && rsp_data.status == ST_RANGE, rsp_data.first_sector == '0 && rsp_data.next_cluster == '0)

   // End of chain on FAT12 means the all-ones 12-bit entry.
   `FCCL_ASSERT_IMP(a_eoc12, rsp_valid && rsp_data.status == ST_END && rsp_data.fat_kind == KIND_FAT12, rsp_data.next_cluster == EOC_FAT12)
endmodule

bind fat_cluster_chain_lookup fccl_checker u_fccl_checker (.*);

[tb/tb_fat_cluster_chain_lookup.sv]
// Self-checking testbench for the FAT cluster chain lookup block.
`timescale 1ns / 100ps

module tb_fat_cluster_chain_lookup;
   import fccl_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   fat_cluster_chain_lookup u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the FAT and of the geometry registers.
   logic [7:0]  fat_mem [0:FAT_TABLE_BYTES-1];
   bit          fat_written [0:FAT_TABLE_BYTES-1];
   logic [31:0] geo_bps, geo_spc, geo_res, geo_copies, geo_root;
   logic [31:0] geo_fshort, geo_flong, geo_vol;
   logic [1:0]  cur_kind;
   bit          geo_unsupported;

   rsp_type     pending_lookups [$];
   int unsigned n_items, n_writes, n_lookups, n_results, n_errors;
   int unsigned n_end, n_range, n_unsupp;

   // Sender burst control and receiver stall control.
   bit          gaps_on;
   int unsigned burst_left;
   int unsigned rsp_style;
   int unsigned hold_request;
   int unsigned hold_left;
   int unsigned rcv_cycle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Expected result of one lookup; flags a read of a byte never written.
   function automatic rsp_type chain_entry(input logic [27:0] n, output bit unwritten);
      logic [63:0] root_secs, fat_secs, overhead, data_secs, clusters;
      logic [63:0] off, last, entry, eoc, i;
      logic [1:0]  kind;
      rsp_type     r;
      r = '0;
      r.status = ST_UNSUPP;
      unwritten = 1'b0;
      root_secs = 0;
      if (geo_bps != 0) begin
         root_secs = (64'(geo_root) * 32 + 64'(geo_bps) - 1) / 64'(geo_bps);
      end
      fat_secs = (geo_fshort == 0) ? 64'(geo_flong) : 64'(geo_fshort);
      overhead = 64'(geo_res) + 64'(geo_copies) * fat_secs + root_secs;
      data_secs = (overhead > 64'(geo_vol)) ? 64'd0 : 64'(geo_vol) - overhead;
      if (geo_spc == 0) return r;
      clusters = data_secs / 64'(geo_spc);
      if (clusters < 64'(LIMIT_FAT12) && geo_fshort != 0) kind = KIND_FAT12;
      else if (clusters < 64'(LIMIT_FAT16) && geo_fshort != 0) kind = KIND_FAT16;
      else if (clusters < 64'(LIMIT_FAT32)) kind = KIND_FAT32;
      else return r;
      r.fat_kind = kind;
      if (kind == KIND_FAT12) begin
         off = 64'(n) + 64'(n >> 1);
         last = off + 1;
         eoc = 64'(EOC_FAT12);
      end else if (kind == KIND_FAT16) begin
         off = 64'(n) * 2;
         last = off + 1;
         eoc = 64'(EOC_FAT16);
      end else begin
         off = 64'(n) * 4;
         last = off + 3;
         eoc = 64'(EOC_FAT32);
      end
      if (n < 2 || last >= FAT_TABLE_BYTES) begin
         r.status = ST_RANGE;
         return r;
      end
      for (i = off; i <= last; i++) begin
         if (!fat_written[i[15:0]]) unwritten = 1'b1;
      end
      if (kind == KIND_FAT12) begin
         entry = 64'({fat_mem[off+1], fat_mem[off]});
         if (n[0]) entry = entry >> 4;
         entry = entry & 64'hfff;
      end else if (kind == KIND_FAT16) begin
         entry = 64'({fat_mem[off+1], fat_mem[off]});
      end else begin
         entry = 64'({fat_mem[off+3] & TOP_MASK, fat_mem[off+2], fat_mem[off+1],
                      fat_mem[off]});
      end
      r.status = (entry == eoc) ? ST_END : ST_CONTINUE;
      r.first_sector = 32'((64'(n) - 2) * 64'(geo_spc) + overhead);
      r.next_cluster = entry[27:0];
      return r;
   endfunction

   // Offers one word, waits for its handshake, updates the shadow state and may pause.
   task automatic send_word(input req_type w);
      rsp_type exp_rsp;
      bit      bad;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      n_items++;
      if (w.mode == MODE_WRITE) begin
         fat_mem[w.byte_address] = w.byte_value;
         fat_written[w.byte_address] = 1'b1;
         n_writes++;
      end else begin
         exp_rsp = chain_entry(w.cluster, bad);
         pending_lookups.push_back(exp_rsp);
         n_lookups++;
      end
      if (gaps_on) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 20);
         end
      end
   endtask

   task automatic send_write(input logic [15:0] addr, input logic [7:0] val);
      req_type w;
      w.mode = MODE_WRITE;
      w.byte_address = addr;
      w.byte_value = val;
      w.cluster = 28'($urandom);
      send_word(w);
   endtask

   task automatic send_lookup(input logic [27:0] n);
      req_type w;
      w.mode = MODE_LOOKUP;
      w.byte_address = 16'($urandom);
      w.byte_value = 8'($urandom);
      w.cluster = n;
      send_word(w);
   endtask

   // Lowers valid and waits until every outstanding lookup has answered.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Writes all eight geometry registers while the block is idle.
   task automatic load_geometry(input logic [31:0] bps, spc, res, copies, root,
                                input logic [31:0] fshort, flong, vol);
      logic [31:0] vals [8];
      rsp_type     probe;
      bit          bad;
      vals = '{bps, spc, res, copies, root, fshort, flong, vol};
      drain_results();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IW'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         case (CSR_IW'(i))
            CSR_BPS:      geo_bps    = vals[i] & 32'h1fff;
            CSR_SPC:      geo_spc    = vals[i] & 32'hff;
            CSR_RESERVED: geo_res    = vals[i] & 32'hffff;
            CSR_COPIES:   geo_copies = vals[i] & 32'hff;
            CSR_ROOT:     geo_root   = vals[i] & 32'hffff;
            CSR_FSHORT:   geo_fshort = vals[i] & 32'hffff;
            CSR_FLONG:    geo_flong  = vals[i];
            CSR_VOLUME:   geo_vol    = vals[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
      probe = chain_entry(28'd2, bad);
      geo_unsupported = (probe.status == ST_UNSUPP);
      cur_kind = probe.fat_kind;
   endtask

   // Stores one FAT entry of the current type, keeping the FAT12 neighbor nibble.
   task automatic put_entry(input logic [27:0] n, input logic [27:0] value);
      logic [63:0] off;
      logic [15:0] word;
      if (cur_kind == KIND_FAT12) begin
         off = 64'(n) + 64'(n >> 1);
         word = {fat_mem[off+1], fat_mem[off]};
         if (n[0]) word[15:4] = value[11:0];
         else word[11:0] = value[11:0];
         send_write(off[15:0], word[7:0]);
         send_write(16'(off + 1), word[15:8]);
      end else if (cur_kind == KIND_FAT16) begin
         off = 64'(n) * 2;
         send_write(off[15:0], value[7:0]);
         send_write(16'(off + 1), value[15:8]);
      end else begin
         off = 64'(n) * 4;
         send_write(off[15:0], value[7:0]);
         send_write(16'(off + 1), value[15:8]);
         send_write(16'(off + 2), value[23:16]);
         send_write(16'(off + 3), {4'($urandom), value[27:24]});
      end
   endtask

   // A cluster whose entry lies in the low or the top part of the table.
   function automatic logic [27:0] pick_node();
      bit top;
      top = ($urandom_range(0, 7) == 0);
      case (cur_kind)
         KIND_FAT12: return top ? 28'($urandom_range(43500, 43689)) : 28'($urandom_range(2, 1364));
         KIND_FAT16: return top ? 28'($urandom_range(32700, 32767)) : 28'($urandom_range(2, 1023));
         default:    return top ? 28'($urandom_range(16350, 16383)) : 28'($urandom_range(2, 511));
      endcase
   endfunction

   // Builds a linked chain of entries, then follows it link by link.
   task automatic walk_chain();
      logic [27:0] nodes [$];
      logic [27:0] eoc, value;
      int          len;
      eoc = (cur_kind == KIND_FAT12) ? EOC_FAT12 :
            (cur_kind == KIND_FAT16) ? EOC_FAT16 : EOC_FAT32;
      len = $urandom_range(2, 8);
      for (int i = 0; i < len; i++) nodes.push_back(pick_node());
      for (int i = 0; i < len; i++) begin
         if (i == len - 1) value = ($urandom_range(0, 3) != 0) ? eoc : 28'($urandom);
         else value = nodes[i+1];
         put_entry(nodes[i], value);
      end
      foreach (nodes[i]) send_lookup(nodes[i]);
   endtask

   // One loose word: a scattered write or a lookup that may fall out of range.
   task automatic noise_word();
      logic [27:0] n;
      rsp_type     probe;
      bit          bad;
      int          pick;
      if ($urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 4);
         if (pick < 3) send_write(16'($urandom_range(0, 2047)), 8'($urandom));
         else if (pick == 3) send_write(16'($urandom_range(65280, 65535)), 8'($urandom));
         else send_write(16'($urandom), 8'($urandom));
         return;
      end
      bad = 1'b1;
      for (int t = 0; t < 8 && bad; t++) begin
         n = geo_unsupported ? 28'($urandom) : pick_node();
         probe = chain_entry(n, bad);
      end
      if (bad) begin
         n = ($urandom_range(0, 1) == 0) ? 28'($urandom_range(0, 1))
                                          : 28'($urandom_range(70000, 28'hfffffff));
      end
      send_lookup(n);
   endtask

   // Random traffic, mostly well-formed chains, until the word count is reached.
   task automatic run_traffic(input int unsigned count);
      int unsigned stop_at;
      stop_at = n_items + count;
      while (n_items < stop_at) begin
         if (!geo_unsupported && $urandom_range(0, 9) < 7) walk_chain();
         else noise_word();
      end
   endtask

   // Directed FAT12 checks: shared nibbles, low clusters, table edge, field extremes.
   task automatic test_directed();
      gaps_on = 1'b0;
      rsp_style = 0;
      load_geometry(512, 1, 1, 2, 512, 9, 0, 2880);
      put_entry(28'd2, 28'd3);
      put_entry(28'd3, EOC_FAT12);
      send_lookup(28'd2);
      send_lookup(28'd3);
      send_lookup(28'd0);
      send_lookup(28'd1);
      send_lookup(28'hfffffff);
      send_write(16'd65533, 8'hff);
      send_write(16'd65534, 8'hff);
      send_write(16'hffff, 8'h00);
      send_lookup(28'd43689);
      send_lookup(28'd43690);
      send_write(16'h0000, 8'h00);
      send_write(16'h0001, 8'hff);
      send_lookup(28'd2);
   endtask

   task automatic test_fat12();
      gaps_on = 1'b1;
      rsp_style = 1;
      load_geometry(512, 1, 1, 2, 512, 9, 0, 2880);
      run_traffic(200);
   endtask

   // FAT16 with a long receiver hold while the sender keeps offering words.
   task automatic test_fat16_backpressure();
      gaps_on = 1'b0;
      rsp_style = 2;
      load_geometry(512, 4, 4, 2, 512, 200, 0, 200000);
      hold_request = 400;
      run_traffic(100);
      gaps_on = 1'b1;
      run_traffic(100);
   endtask

   // FAT16 at a large sector size and the largest root size.
   task automatic test_fat16_extremes();
      gaps_on = 1'b1;
      rsp_style = 3;
      load_geometry(4096, 1, 1, 1, 65535, 256, 0, 40000);
      run_traffic(150);
   endtask

   task automatic test_fat32();
      gaps_on = 1'b1;
      rsp_style = 1;
      load_geometry(512, 8, 32, 2, 0, 0, 1000, 1000000);
      run_traffic(200);
   endtask

   // Overhead far above the volume: zero clusters and a wrapped first data sector.
   task automatic test_fat32_wrap();
      gaps_on = 1'b1;
      rsp_style = 0;
      load_geometry(4096, 128, 65535, 255, 0, 0, 32'hffffffff, 32'hffffffff);
      run_traffic(120);
   endtask

   // Zero cluster size, then too many clusters with a zero sector size.
   task automatic test_unsupported();
      gaps_on = 1'b1;
      rsp_style = 2;
      load_geometry(512, 0, 1, 2, 512, 0, 100, 100000);
      run_traffic(50);
      load_geometry(0, 1, 0, 1, 65535, 0, 1, 32'hffffffff);
      run_traffic(50);
   endtask

   // Random geometry, one round shaped toward small FAT12 volumes and one toward FAT32.
   task automatic test_random_geometry();
      gaps_on = 1'b1;
      rsp_style = 3;
      load_geometry($urandom_range(0, 8191), $urandom_range(0, 255), $urandom_range(0, 65535),
                    $urandom_range(0, 255), $urandom_range(0, 65535),
                    ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 65535),
                    $urandom, $urandom);
      run_traffic(100);
      load_geometry(512, $urandom_range(1, 4), $urandom_range(1, 32), $urandom_range(1, 2),
                    $urandom_range(16, 512), $urandom_range(1, 12), $urandom,
                    $urandom_range(100, 20000));
      run_traffic(150);
      rsp_style = 1;
      load_geometry($urandom_range(512, 4096), $urandom_range(1, 128), $urandom_range(1, 64),
                    2, 0, 0, $urandom_range(1, 20000), $urandom);
      run_traffic(150);
   endtask

   // Receiver: a hold when asked, otherwise one of several stall patterns.
   always @(posedge clock) begin
      rcv_cycle++;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rsp_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= (rcv_cycle % 7) >= 3;
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_lookups.size() == 0) begin
            n_errors++;
            if (n_errors <= 40)
               $display("%0t: unexpected result word %h", $time, rsp_data);
         end else begin
            exp_rsp = pending_lookups.pop_front();
            if (exp_rsp.status == ST_END) n_end++;
            if (exp_rsp.status == ST_RANGE) n_range++;
            if (exp_rsp.status == ST_UNSUPP) n_unsupp++;
            if (rsp_data !== exp_rsp) begin
               n_errors++;
               if (n_errors <= 40) begin
                  if (rsp_data.status !== exp_rsp.status)
                     $display("%0t: status expected %0d actual %0d", $time,
                              exp_rsp.status, rsp_data.status);
                  if (rsp_data.first_sector !== exp_rsp.first_sector)
                     $display("%0t: first_sector expected %h actual %h", $time,
                              exp_rsp.first_sector, rsp_data.first_sector);
                  if (rsp_data.next_cluster !== exp_rsp.next_cluster)
                     $display("%0t: next_cluster expected %h actual %h", $time,
                              exp_rsp.next_cluster, rsp_data.next_cluster);
                  if (rsp_data.fat_kind !== exp_rsp.fat_kind)
                     $display("%0t: fat_kind expected %0d actual %0d", $time,
                              exp_rsp.fat_kind, rsp_data.fat_kind);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b0;
      burst_left = 1;
      rsp_style = 0;
      hold_request = 0;
      hold_left = 0;
      rcv_cycle = 0;
      geo_bps = 512; geo_spc = 1; geo_res = 1; geo_copies = 2;
      geo_root = 512; geo_fshort = 0; geo_flong = 0; geo_vol = 0;
      foreach (fat_written[i]) begin
         fat_written[i] = 1'b0;
         fat_mem[i] = 8'h00;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fat12();
      test_fat16_backpressure();
      test_fat16_extremes();
      test_fat32();
      test_fat32_wrap();
      test_unsupported();
      test_random_geometry();

      drain_results();
      repeat (20) @(posedge clock);
      if (pending_lookups.size() != 0) n_errors++;
      $display("Sent %0d words: %0d FAT byte writes and %0d lookups over 11 geometries.",
               n_items, n_writes, n_lookups);
      $display("Checked %0d results: %0d end of chain, %0d out of range, %0d unsupported.",
               n_results, n_end, n_range, n_unsupp);
      if (n_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fccl_pkg.sv
rtl/core/fccl_ram.sv
rtl/core/fccl_div.sv
rtl/core/fccl_geom.sv
rtl/core/fat_cluster_chain_lookup.sv
rtl/core/fccl_checker.sv
tb/tb_fat_cluster_chain_lookup.sv
